[rtl/crc64rs_pkg.sv]
// crc64rs_pkg: shared widths, reset polynomial and the single-bit CRC step
// for the reflected CRC-64 stream block. No dependencies.

package crc64rs_pkg;

    localparam int CRC_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 3;

    // ECMA-182 polynomial, bit-reversed
    localparam logic [CRC_W-1:0] POLY_RESET = 64'hC96C_5795_D787_0F42;

    typedef logic [CRC_W-1:0] crc_word_t;

    // One LSB-first shift of the CRC register
    function automatic crc_word_t crc_step(input crc_word_t value, input crc_word_t poly);
        crc_word_t shifted;
        shifted = value >> 1;
        if (value[0])
        begin
            shifted = shifted ^ poly;
        end
        return shifted;
    endfunction

endpackage

[rtl/crc64rs_basis.sv]
// crc64rs_basis: holds the polynomial register and builds the basis words
// (polynomial advanced 0..N-1 bit steps) one per cycle after reset or a write.
// Depends on crc64rs_pkg.

module crc64rs_basis
    import crc64rs_pkg::*;
#(
    parameter int BASIS_N = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [CRC_W-1:0]            cfg_data,
    output logic [BASIS_N-1:0][CRC_W-1:0] basis,
    output logic                        busy
);

    localparam int IDX_W = (BASIS_N > 1) ? $clog2(BASIS_N) : 1;

    crc_word_t  poly_reg, poly_next;
    crc_word_t  work_reg, work_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    crc_word_t  basis_reg [BASIS_N];

    always_comb
    begin
        poly_next = poly_reg;
        work_next = work_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (cfg_valid)
        begin
            // new polynomial restarts the sweep
            poly_next = cfg_data;
            work_next = cfg_data;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = crc_step(work_reg, poly_reg);
            idx_next  = idx_reg + 1'b1;
            if (idx_reg == IDX_W'(BASIS_N - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= POLY_RESET;
            work_reg <= POLY_RESET;
            idx_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            poly_reg <= poly_next;
            work_reg <= work_next;
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_valid)
        begin
            basis_reg[idx_reg] <= work_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < BASIS_N; i++)
        begin
            basis[i] = basis_reg[i];
        end
    end

    assign busy = busy_reg;

endmodule

[rtl/crc64rs_lane.sv]
// crc64rs_lane: folding contribution of one byte lane, as the XOR of the
// basis words selected by the lane byte's set bits. Depends on crc64rs_pkg.

module crc64rs_lane
    import crc64rs_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 4,
    parameter int LANE           = 0
)
(
    input  logic [BYTE_W-1:0]                       lane_byte,
    input  logic [$clog2(BYTES_PER_ITEM+1)-1:0]     count,
    input  logic [BYTE_W*BYTES_PER_ITEM-1:0][CRC_W-1:0] basis,
    output logic [CRC_W-1:0]                        contrib
);

    localparam int BASIS_N = BYTE_W * BYTES_PER_ITEM;
    localparam int IDX_W   = $clog2(BASIS_N);

    logic [IDX_W-1:0] lane_end;

    // bit j of this lane is followed by (lane_end - j) further shifts
    assign lane_end = IDX_W'((int'(count) - LANE) * BYTE_W - 1);

    always_comb
    begin
        contrib = '0;
        if (int'(count) > LANE)
        begin
            for (int j = 0; j < BYTE_W; j++)
            begin
                if (lane_byte[j])
                begin
                    contrib = contrib ^ basis[lane_end - IDX_W'(j)];
                end
            end
        end
    end

endmodule

[rtl/crc64_reflected_stream_top.sv]
// crc64_reflected_stream_top: reflected CRC-64 over a byte stream, one item
// per clock while in_ready is high. Depends on crc64rs_pkg, crc64rs_basis and crc64rs_lane.
//
// Usage:
//  - Input channel (in_valid/in_ready): data_bytes carries up to
//    BYTES_PER_ITEM bytes, byte 0 in bits 7:0 first; byte_count gives the
//    valid bytes (saturated at BYTES_PER_ITEM); start_flag loads seed_value
//    (a previous CRC, 0 for a new message) before the bytes are folded in.
//  - Output channel (out_valid/out_ready): one crc_value per input transfer,
//    the CRC of every byte so far with the final inversion applied.
//  - Config channel (cfg_valid/cfg_ready/cfg_data): writes the reflected
//    polynomial; always ready. Write only while no item is in flight.
//  - The result is registered and appears in the cycle after the input
//    transfer. One item per cycle while in_ready is high, since the
//    running remainder is updated combinationally (lane XOR tree plus merge).
//  - After reset and after every polynomial write, the basis builder derives
//    the 8*BYTES_PER_ITEM per-bit basis words (32 by default), one per
//    cycle; in_ready stays low during that sweep.
//  - Reset loads the ECMA-182 polynomial and an all-ones remainder.
//  - A stalled receiver holds the result register; a new item is taken in
//    the same cycle the held result is drained, so no bubble appears.

module crc64_reflected_stream_top
    import crc64rs_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    // config write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CRC_W-1:0]    cfg_data,
    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [DATA_W-1:0]   data_bytes,
    input  logic [COUNT_W-1:0]  byte_count,
    input  logic                start_flag,
    input  logic [CRC_W-1:0]    seed_value,
    // output channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CRC_W-1:0]    crc_value
);

    localparam int BASIS_N = BYTE_W * BYTES_PER_ITEM;
    localparam int CNT_W   = $clog2(BYTES_PER_ITEM + 1);

    logic [BASIS_N-1:0][CRC_W-1:0] basis;
    logic                          basis_busy;

    crc_word_t  remainder_reg, remainder_next;
    crc_word_t  crc_reg, crc_next;
    logic       out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]  count_sat;
    crc_word_t         rem_in;
    crc_word_t         rem_new;
    crc_word_t         lane_contrib [BYTES_PER_ITEM];
    logic              in_xfer;

    // ------------------------------------------------------------------
    // Basis words: polynomial advanced 0..BASIS_N-1 bit steps
    // ------------------------------------------------------------------
    crc64rs_basis #(
        .BASIS_N (BASIS_N)
    ) u_basis (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .basis     (basis),
        .busy      (basis_busy)
    );

    assign cfg_ready = 1'b1;

    // Output slot free or draining this cycle, and basis sweep finished
    assign in_ready = !basis_busy && (!out_valid_reg || out_ready);
    assign in_xfer  = in_valid && in_ready;

    // Byte count above the item size saturates
    always_comb
    begin
        if (int'(byte_count) > BYTES_PER_ITEM)
        begin
            count_sat = CNT_W'(BYTES_PER_ITEM);
        end
        else
        begin
            count_sat = CNT_W'(byte_count);
        end
    end

    // Seed load ahead of folding: the register holds the inverted CRC
    assign rem_in = start_flag ? ~seed_value : remainder_reg;

    // ------------------------------------------------------------------
    // Byte lanes. Folding n bytes equals 8n steps of a linear map:
    //   R' = (V >> 8n) ^ XOR over set bits i < 8n of V of basis[8n-1-i]
    // with V = R ^ data. Each lane handles the eight bits of one byte.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < BYTES_PER_ITEM; k++)
    begin : g_lane
        logic [BYTE_W-1:0] lane_byte;

        if (k < DATA_W / BYTE_W)
        begin : g_data
            assign lane_byte = rem_in[k*BYTE_W +: BYTE_W] ^ data_bytes[k*BYTE_W +: BYTE_W];
        end
        else
        begin : g_zero
            // lanes past the data field fold zero bytes
            assign lane_byte = rem_in[k*BYTE_W +: BYTE_W];
        end

        crc64rs_lane #(
            .BYTES_PER_ITEM (BYTES_PER_ITEM),
            .LANE           (k)
        ) u_lane (
            .lane_byte (lane_byte),
            .count     (count_sat),
            .basis     (basis),
            .contrib   (lane_contrib[k])
        );
    end

    // Merge: shifted-down upper remainder XOR all lane contributions
    always_comb
    begin
        rem_new = rem_in >> {count_sat, 3'b000};
        for (int k = 0; k < BYTES_PER_ITEM; k++)
        begin
            rem_new = rem_new ^ lane_contrib[k];
        end
    end

    // ------------------------------------------------------------------
    // Running remainder and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        remainder_next = remainder_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (in_xfer)
        begin
            remainder_next = rem_new;
            crc_next       = ~rem_new;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remainder_reg <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remainder_reg <= remainder_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

    assign out_valid = out_valid_reg;
    assign crc_value = crc_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Empty item with seed load reports the seed itself
    a_seed_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && start_flag && (byte_count == '0)
        |=> crc_value == $past(seed_value))
        else $error("empty seeded item did not return the seed");

    // Empty item without seed reports the current CRC
    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !start_flag && (byte_count == '0)
        |=> crc_value == ~$past(remainder_reg))
        else $error("empty item changed the running CRC");

    // A polynomial write blocks input until the basis is rebuilt
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("input accepted during basis rebuild");

    // Every transfer produces a result in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

endmodule

[tb/crc64_stream_checker.sv]
`timescale 1ns / 100ps
// crc64_stream_checker: watches the config, input and output channels of the
// reflected CRC-64 stream block, predicts each CRC and compares it.
// Depends on crc64rs_pkg.

module crc64_stream_checker
    import crc64rs_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CRC_W-1:0]    cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [DATA_W-1:0]   data_bytes,
    input  logic [COUNT_W-1:0]  byte_count,
    input  logic                start_flag,
    input  logic [CRC_W-1:0]    seed_value,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [CRC_W-1:0]    crc_value,
    output int                  mismatches,
    output int                  outstanding
);

    crc_word_t poly_model;
    crc_word_t remainder_model;
    crc_word_t crc_queue[$];
    int        fail_total;

    // Fold the valid bytes of one item into the inverted register, LSB first
    function automatic crc_word_t fold_item(input crc_word_t rem, input crc_word_t poly,
                                            input logic [DATA_W-1:0] data,
                                            input logic [COUNT_W-1:0] count);
        crc_word_t   r;
        logic [7:0]  lane;
        int unsigned nbytes;
        r = rem;
        nbytes = (count > BYTES_PER_ITEM) ? BYTES_PER_ITEM : count;
        for (int k = 0; k < nbytes; k++)
        begin
            lane = (k < DATA_W / 8) ? data[8*k +: 8] : 8'h00;
            r = r ^ {{(CRC_W-8){1'b0}}, lane};
            for (int b = 0; b < 8; b++)
            begin
                r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input crc_word_t got,
                                   input crc_word_t want);
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        fail_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        crc_word_t want;
        if (!rst_n)
        begin
            poly_model      = POLY_RESET;
            remainder_model = '1;
            crc_queue.delete();
            fail_total      = 0;
        end
        else
        begin
            // results first: an output transfer never belongs to an input
            // transfer at the same edge
            if (out_valid && out_ready)
            begin
                if (crc_queue.size() == 0)
                begin
                    report_mismatch("unexpected crc_value", crc_value, '0);
                end
                else
                begin
                    want = crc_queue.pop_front();
                    if (crc_value !== want)
                    begin
                        report_mismatch("crc_value", crc_value, want);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                poly_model = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                if (start_flag)
                begin
                    remainder_model = ~seed_value;
                end
                remainder_model = fold_item(remainder_model, poly_model, data_bytes,
                                            byte_count);
                crc_queue.push_back(~remainder_model);
            end
        end
        mismatches  <= fail_total;
        outstanding <= crc_queue.size();
    end

endmodule

[tb/tb_crc64_reflected_stream_top.sv]
`timescale 1ns / 100ps
// tb_crc64_reflected_stream_top: stimulus and verdict for the reflected CRC-64
// stream block. Depends on crc64rs_pkg, crc64_reflected_stream_top and
// crc64_stream_checker.

module tb_crc64_reflected_stream_top;
    import crc64rs_pkg::*;

    localparam int BYTES_PER_ITEM = 4;
    localparam int HOLD_CYCLES    = 60;       // long receiver hold-off
    localparam int PHASE_ITEMS    = 150;      // minimum random items per polynomial setting
    localparam int TIMEOUT_NS     = 4_000_000;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [CRC_W-1:0]    cfg_data   = '0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [DATA_W-1:0]   data_bytes = '0;
    logic [COUNT_W-1:0]  byte_count = '0;
    logic                start_flag = 1'b0;
    logic [CRC_W-1:0]    seed_value = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [CRC_W-1:0]    crc_value;

    int mismatches;
    int outstanding;

    // idling controls shared by the sender and the receiver processes
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_req     = 1'b0;

    int unsigned items_sent;

    crc64_reflected_stream_top #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_bytes (data_bytes),
        .byte_count (byte_count),
        .start_flag (start_flag),
        .seed_value (seed_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .crc_value  (crc_value)
    );

    crc64_stream_checker #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_bytes  (data_bytes),
        .byte_count  (byte_count),
        .start_flag  (start_flag),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .crc_value   (crc_value),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #TIMEOUT_NS;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: drops out_ready about 16% of cycles while idling is on. A hold
    // request parks out_ready low until hold_req clears, so the result register
    // stays full and the block has to back-pressure the sender.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= !(sink_idle_on && ($urandom_range(0, 99) < 16));
        end
    end

    // One input transfer. Random idle cycles go in front of it; while idle the
    // payload is scrambled to show the block only looks at it on a transfer.
    // in_valid stays high on return, so the caller either sends the next item
    // in the same step or calls wait_for_results to drop it.
    task automatic send_word(input logic [DATA_W-1:0] data,
                             input logic [COUNT_W-1:0] count,
                             input logic start,
                             input logic [CRC_W-1:0] seed);
        while (src_idle_on && ($urandom_range(0, 99) < 16))
        begin
            in_valid   <= 1'b0;
            data_bytes <= $urandom;
            seed_value <= {$urandom, $urandom};
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_bytes <= data;
        byte_count <= count;
        start_flag <= start;
        seed_value <= seed;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        items_sent++;
    endtask

    // Stop offering input and wait until the checker holds no expectation.
    // The first edge lets a transfer taken at the current edge be counted.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Polynomial write, only with the pipeline empty. The block then rebuilds
    // its basis words with in_ready low; the next send_word simply waits.
    task automatic write_polynomial(input logic [CRC_W-1:0] poly);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= poly;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly full words; the rest spread over every count, empty and
    // oversized ones included.
    function automatic logic [COUNT_W-1:0] pick_count();
        if ($urandom_range(0, 9) < 6)
        begin
            return 3'd4;
        end
        return 3'($urandom_range(0, 7));
    endfunction

    // A message: a seeded start transfer, then continuation transfers whose
    // seed field is noise (ignored without the start flag).
    task automatic send_message(input int unsigned words);
        logic [CRC_W-1:0] seed;
        seed = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
        send_word($urandom, pick_count(), 1'b1, seed);
        for (int i = 1; i < words; i++)
        begin
            send_word($urandom, pick_count(), 1'b0, {$urandom, $urandom});
        end
    endtask

    // Random traffic under one polynomial setting
    task automatic run_phase(input logic [CRC_W-1:0] poly);
        int unsigned phase_end;
        write_polynomial(poly);
        phase_end = items_sent + PHASE_ITEMS;
        while (items_sent < phase_end)
        begin
            // occasionally a stray continuation with no start in front
            if ($urandom_range(0, 9) == 0)
            begin
                send_word($urandom, pick_count(), 1'b0, {$urandom, $urandom});
            end
            send_message($urandom_range(1, 12));
        end
    endtask

    initial
    begin
        items_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed, reset polynomial ---
        // "123456789" split 4/4/1: the standard check string
        send_word(32'h3433_3231, 3'd4, 1'b1, 64'h0);
        send_word(32'h3837_3635, 3'd4, 1'b0, 64'h0);
        send_word(32'h0000_0039, 3'd1, 1'b0, 64'h0);
        // empty item keeps the running CRC
        send_word(32'hFFFF_FFFF, 3'd0, 1'b0, '1);
        // empty item with a start returns the seed itself
        send_word(32'hFFFF_FFFF, 3'd0, 1'b1, {$urandom, $urandom});
        // counts above the item size saturate
        send_word(32'hFFFF_FFFF, 3'd7, 1'b0, 64'h0);
        send_word($urandom, 3'd5, 1'b0, 64'h0);
        send_word($urandom, 3'd6, 1'b0, 64'h0);
        // seed extremes
        send_word(32'h0000_0000, 3'd4, 1'b1, '1);
        send_word(32'h0000_0000, 3'd4, 1'b1, 64'h0);
        send_word($urandom, 3'd1, 1'b0, 64'h0);
        send_word($urandom, 3'd2, 1'b0, 64'h0);
        send_word($urandom, 3'd3, 1'b0, 64'h0);
        // resume from an arbitrary earlier CRC
        send_word($urandom, 3'd2, 1'b1, {$urandom, $urandom});

        // polynomial extremes
        write_polynomial('0);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1, 64'h0);
        send_word($urandom, 3'd3, 1'b0, 64'h0);
        send_word($urandom, 3'd0, 1'b1, '1);
        write_polynomial('1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1, 64'h0);
        send_word(32'h8000_0001, 3'd4, 1'b0, 64'h0);
        send_word($urandom, 3'd7, 1'b1, {$urandom, $urandom});

        // --- random traffic ---
        run_phase(POLY_RESET);

        // long receiver stall while the sender keeps offering items
        hold_req = 1'b1;
        send_message(12);
        run_phase({$urandom, $urandom});

        // pause the sender mid-stream until every result is back
        send_message(6);
        wait_for_results();
        run_phase({1'b1, 31'($urandom), $urandom});

        // a long stretch without idling on either side
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_phase(POLY_RESET);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_message(8);

        // drain, then wait quietly to catch stray results
        wait_for_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
